FILE: rtl/core/ldfp_pkg.sv
// Package for the LoRaWAN data frame parser.
// Holds the byte class codes, frame layout constants and the result type.
// No dependencies.
package ldfp_pkg;

   localparam logic [3:0] OPTS_LEN_MASK = 4'hF;
   localparam int unsigned HDR_BASE = 8;
   localparam int unsigned MIC_BYTES = 4;

   localparam logic [7:0] ADDR_LAST_POS = 8'd4;
   localparam logic [7:0] CTRL_POS = 8'd5;
   localparam logic [7:0] CNT_LOW_POS = 8'd6;
   localparam logic [7:0] CNT_HIGH_POS = 8'd7;
   localparam logic [7:0] POS_MAX = 8'd255;

   localparam logic [2:0] MTYPE_JOIN_REQUEST = 3'd0;
   localparam logic [2:0] MTYPE_JOIN_ACCEPT = 3'd1;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   typedef enum logic [2:0] {
      CLASS_MHDR = 3'd0,
      CLASS_ADDR = 3'd1,
      CLASS_FCTRL = 3'd2,
      CLASS_FCNT = 3'd3,
      CLASS_FOPTS = 3'd4,
      CLASS_FPORT = 3'd5,
      CLASS_BODY = 3'd6,
      CLASS_MIC = 3'd7
   } byte_class_type;

   typedef struct packed {
      logic is_summary;
      logic [2:0] byte_class;
      logic [7:0] byte_value;
      logic status;
      logic [2:0] message_type;
      logic [31:0] device_address;
      logic [7:0] frame_control;
      logic [15:0] frame_counter;
      logic [7:0] frame_port;
      logic port_present;
      logic [7:0] payload_length;
      logic [31:0] message_check;
   } result_type;

endpackage

FILE: rtl/core/ldfp_if.sv
// Channel interfaces of the LoRaWAN data frame parser.
// One interface carries frame bytes in, the other carries results out.
// No dependencies.
interface ldfp_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic [7:0] frame_length;
   logic first_byte;
   logic last_byte;

   modport source (output valid, data_byte, frame_length, first_byte, last_byte,
                   input ready);
   modport sink (input valid, data_byte, frame_length, first_byte, last_byte,
                 output ready);
endinterface

interface ldfp_rsp_if;
   logic valid;
   logic ready;
   logic is_summary;
   logic [2:0] byte_class;
   logic [7:0] byte_value;
   logic status;
   logic [2:0] message_type;
   logic [31:0] device_address;
   logic [7:0] frame_control;
   logic [15:0] frame_counter;
   logic [7:0] frame_port;
   logic port_present;
   logic [7:0] payload_length;
   logic [31:0] message_check;

   modport source (output valid, is_summary, byte_class, byte_value, status,
                   message_type, device_address, frame_control, frame_counter,
                   frame_port, port_present, payload_length, message_check,
                   input ready);
   modport sink (input valid, is_summary, byte_class, byte_value, status,
                 message_type, device_address, frame_control, frame_counter,
                 frame_port, port_present, payload_length, message_check,
                 output ready);
endinterface

FILE: rtl/core/lorawan_data_frame_parser_top.sv
// The parser takes one frame byte per cycle while its output is not stalled
// and returns one tagged beat per byte; the final byte of a frame also returns
// a summary beat, so it holds off the input while the summary leaves through
// the single result register. Join frames are decoded as far as the MHDR only,
// and a data frame too short for its header and MIC is reported with a status
// of one.
//
// Top level of the LoRaWAN data frame parser.
// Depends on ldfp_pkg and the channel interfaces in ldfp_if.
module lorawan_data_frame_parser_top (
   input logic clock,
   input logic reset,
   ldfp_req_if.sink req_chan,
   ldfp_rsp_if.source rsp_chan
);
   import ldfp_pkg::*;

   logic [7:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [2:0] type_ff, type_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0] ctrl_ff, ctrl_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0] port_ff, port_in;
   logic [31:0] mic_ff, mic_in;

   result_type out_ff, sum_ff;
   logic out_valid_ff, sum_pend_ff;
   result_type tag_res, sum_res;

   logic [7:0] pos_cur, len_cur;
   logic [2:0] type_cur, type_nx;
   logic [31:0] addr_cur, addr_nx, mic_cur, mic_nx;
   logic [7:0] ctrl_cur, ctrl_nx, port_cur, port_nx;
   logic [15:0] cnt_cur, cnt_nx;
   logic [8:0] hdr_len, hdr_mic, sum_hdr, sum_hdr_mic, len_ext;
   logic [7:0] mic_start;
   logic [1:0] addr_lane, mic_lane;
   logic join_cur, join_nx, accept;
   byte_class_type cls;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !sum_pend_ff && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      pos_cur = req_chan.first_byte ? 8'd0 : pos_ff;
      len_cur = req_chan.first_byte ? req_chan.frame_length : len_ff;
      type_cur = req_chan.first_byte ? 3'd0 : type_ff;
      addr_cur = req_chan.first_byte ? 32'd0 : addr_ff;
      ctrl_cur = req_chan.first_byte ? 8'd0 : ctrl_ff;
      cnt_cur = req_chan.first_byte ? 16'd0 : cnt_ff;
      port_cur = req_chan.first_byte ? 8'd0 : port_ff;
      mic_cur = req_chan.first_byte ? 32'd0 : mic_ff;

      len_ext = {1'b0, len_cur};
      hdr_len = 9'(HDR_BASE) + 9'(ctrl_cur[3:0] & OPTS_LEN_MASK);
      hdr_mic = hdr_len + 9'(MIC_BYTES);
      mic_start = len_cur - 8'(MIC_BYTES);
      addr_lane = 2'(pos_cur - 8'd1);
      mic_lane = 2'(pos_cur - mic_start);
      join_cur = (type_cur == MTYPE_JOIN_REQUEST) || (type_cur == MTYPE_JOIN_ACCEPT);

      type_nx = type_cur;
      addr_nx = addr_cur;
      ctrl_nx = ctrl_cur;
      cnt_nx = cnt_cur;
      port_nx = port_cur;
      mic_nx = mic_cur;

      if (pos_cur == 8'd0) begin
         cls = CLASS_MHDR;
         type_nx = req_chan.data_byte[7:5];
      end else if (join_cur) begin
         cls = CLASS_BODY;
      end else if (pos_cur <= ADDR_LAST_POS) begin
         cls = CLASS_ADDR;
         addr_nx[addr_lane*8 +: 8] = req_chan.data_byte;
      end else if (pos_cur == CTRL_POS) begin
         cls = CLASS_FCTRL;
         ctrl_nx = req_chan.data_byte;
      end else if (pos_cur <= CNT_HIGH_POS) begin
         cls = CLASS_FCNT;
         if (pos_cur == CNT_LOW_POS) begin
            cnt_nx[7:0] = req_chan.data_byte;
         end else begin
            cnt_nx[15:8] = req_chan.data_byte;
         end
      end else if ({1'b0, pos_cur} < hdr_len) begin
         cls = CLASS_FOPTS;
      end else if (len_ext >= hdr_mic && pos_cur < len_cur && pos_cur >= mic_start) begin
         cls = CLASS_MIC;
         mic_nx[mic_lane*8 +: 8] = req_chan.data_byte;
      end else if (len_ext > hdr_mic && {1'b0, pos_cur} == hdr_len) begin
         cls = CLASS_FPORT;
         port_nx = req_chan.data_byte;
      end else begin
         cls = CLASS_BODY;
      end

      tag_res = '0;
      tag_res.byte_class = cls;
      tag_res.byte_value = req_chan.data_byte;

      join_nx = (type_nx == MTYPE_JOIN_REQUEST) || (type_nx == MTYPE_JOIN_ACCEPT);
      sum_hdr = 9'(HDR_BASE) + 9'(ctrl_nx[3:0] & OPTS_LEN_MASK);
      sum_hdr_mic = sum_hdr + 9'(MIC_BYTES);
      sum_res = '0;
      sum_res.is_summary = 1'b1;
      sum_res.status = STATUS_OK;
      sum_res.message_type = type_nx;
      if (!join_nx) begin
         sum_res.device_address = addr_nx;
         sum_res.frame_control = ctrl_nx;
         sum_res.frame_counter = cnt_nx;
         if (len_ext < sum_hdr_mic) begin
            sum_res.status = STATUS_SHORT;
         end else begin
            if (len_ext > sum_hdr_mic) begin
               sum_res.frame_port = port_nx;
               sum_res.port_present = 1'b1;
               sum_res.payload_length = 8'(len_ext - sum_hdr_mic - 9'd1);
            end
            sum_res.message_check = mic_nx;
         end
      end

      len_in = len_cur;
      if (req_chan.last_byte) begin
         pos_in = 8'd0;
         type_in = 3'd0;
         addr_in = 32'd0;
         ctrl_in = 8'd0;
         cnt_in = 16'd0;
         port_in = 8'd0;
         mic_in = 32'd0;
      end else begin
         pos_in = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 8'd1;
         type_in = type_nx;
         addr_in = addr_nx;
         ctrl_in = ctrl_nx;
         cnt_in = cnt_nx;
         port_in = port_nx;
         mic_in = mic_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         len_ff <= '0;
         type_ff <= '0;
         addr_ff <= '0;
         ctrl_ff <= '0;
         cnt_ff <= '0;
         port_ff <= '0;
         mic_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         type_ff <= type_in;
         addr_ff <= addr_in;
         ctrl_ff <= ctrl_in;
         cnt_ff <= cnt_in;
         port_ff <= port_in;
         mic_ff <= mic_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sum_pend_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
         sum_pend_ff <= req_chan.last_byte;
      end else if (out_valid_ff && rsp_chan.ready) begin
         out_valid_ff <= sum_pend_ff;
         sum_pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= tag_res;
         sum_ff <= sum_res;
      end else if (out_valid_ff && rsp_chan.ready && sum_pend_ff) begin
         out_ff <= sum_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.is_summary = out_ff.is_summary;
   assign rsp_chan.byte_class = out_ff.byte_class;
   assign rsp_chan.byte_value = out_ff.byte_value;
   assign rsp_chan.status = out_ff.status;
   assign rsp_chan.message_type = out_ff.message_type;
   assign rsp_chan.device_address = out_ff.device_address;
   assign rsp_chan.frame_control = out_ff.frame_control;
   assign rsp_chan.frame_counter = out_ff.frame_counter;
   assign rsp_chan.frame_port = out_ff.frame_port;
   assign rsp_chan.port_present = out_ff.port_present;
   assign rsp_chan.payload_length = out_ff.payload_length;
   assign rsp_chan.message_check = out_ff.message_check;

`ifndef SYNTHESIS
   a_pend_has_beat: assert property (@(posedge clock) disable iff (reset)
      sum_pend_ff |-> (out_valid_ff && !out_ff.is_summary))
      else $error("Summary pending without a tagged beat in front of it.");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.last_byte) |=> (pos_ff == 8'd0 && ctrl_ff == 8'd0))
      else $error("Frame state not cleared after the last byte.");

   a_short_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.is_summary && out_ff.status == STATUS_SHORT)
      |-> (!out_ff.port_present && out_ff.payload_length == 8'd0
           && out_ff.message_check == 32'd0))
      else $error("Short frame summary carries port or MIC data.");

   a_summary_follows: assert property (@(posedge clock) disable iff (reset)
      (sum_pend_ff && rsp_chan.ready) |=> (out_valid_ff && out_ff.is_summary))
      else $error("Summary beat did not follow its tagged beat.");
`endif

endmodule
